// ===== rtl/tllc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllc_pkg
// Shared types and result codes for the three-level LRU cache lookup.
// ----------------------------------------------------------------------------
package tllc_pkg;

    localparam int LEVEL_W = 2;

    // Result codes: first level that held the line
    typedef enum logic [LEVEL_W-1:0] {
        HIT_L1   = 2'd0,
        HIT_L2   = 2'd1,
        HIT_L3   = 2'd2,
        MISS_ALL = 2'd3
    } level_code_t;

endpackage

// ===== rtl/tllc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllc_cell
// One line slot of a recency-ordered chain. Position in the chain is the
// LRU rank; on update the cell takes its left neighbor's line unless a
// match was already found further left.
// ----------------------------------------------------------------------------
module tllc_cell #(
    parameter int TAG_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             update_en,
    input  logic [TAG_W-1:0] probe_tag,
    input  logic [TAG_W-1:0] left_tag,
    input  logic             left_valid,
    input  logic             found_in,
    output logic             found_out,
    output logic [TAG_W-1:0] tag_out,
    output logic             valid_out
);

    logic [TAG_W-1:0] tag_reg;
    logic             valid_reg;
    logic             match;
    logic             shift;

    assign match     = valid_reg && (tag_reg == probe_tag);
    assign found_out = found_in | match;
    assign tag_out   = tag_reg;
    assign valid_out = valid_reg;

    // matching cell also shifts: its line reappears at the head
    assign shift = update_en && !found_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= left_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            tag_reg <= left_tag;
        end
    end

endmodule

// ===== rtl/tllc_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllc_level
// One fully associative cache level built as a chain of LRU cells.
// Head of the chain is most recent; the tail line drops out on a full miss.
// ----------------------------------------------------------------------------
module tllc_level #(
    parameter int LINES = 2,
    parameter int TAG_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             update_en,
    input  logic [TAG_W-1:0] probe_tag,
    output logic             hit
);

    logic [TAG_W-1:0] chain_tag   [0:LINES];
    logic             chain_valid [0:LINES];
    logic             chain_found [0:LINES];

    assign chain_tag[0]   = probe_tag;
    assign chain_valid[0] = 1'b1;
    assign chain_found[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < LINES; i++) begin : g_cell
            tllc_cell #(
                .TAG_W (TAG_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .update_en  (update_en),
                .probe_tag  (probe_tag),
                .left_tag   (chain_tag[i]),
                .left_valid (chain_valid[i]),
                .found_in   (chain_found[i]),
                .found_out  (chain_found[i+1]),
                .tag_out    (chain_tag[i+1]),
                .valid_out  (chain_valid[i+1])
            );
        end
    endgenerate

    assign hit = chain_found[LINES];

endmodule

// ===== rtl/three_level_lru_cache_lookup_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_lru_cache_lookup_top
// Reports which level of an L1/L2/L3 fully associative LRU hierarchy hits.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_address carry one byte-address request per handshake.
//   m_valid/m_ready/m_hit_level return one code per request, in order:
//   0 = L1 hit, 1 = L2 hit, 2 = L3 hit, 3 = missed every level.
// Operation:
//   The tag step turns the address into a line tag (reciprocal multiply,
//   result registered). The lookup step then probes all three cell chains
//   in parallel, updates each level down to the first that hits (all of
//   them on a miss) and loads the output register. A new request is not
//   taken until the pending one has been looked up; s_ready drops while a
//   request waits for its lookup, and the next request can be taken while
//   a finished result still waits in the output register.
// Stall:
//   If m_ready stays low, the pending lookup waits with cache state intact
//   until the output register frees up; s_ready stays low meanwhile.
// Reset:
//   aresetn (synchronous, active low) invalidates every line in all levels
//   and empties the pipeline; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module three_level_lru_cache_lookup_top
    import tllc_pkg::*;
#(
    parameter int ADDR_WIDTH   = 16,
    parameter int LINE_BYTES   = 16,
    parameter int FIRST_LINES  = 2,
    parameter int SECOND_LINES = 4,
    parameter int THIRD_LINES  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADDR_WIDTH-1:0] s_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LEVEL_W-1:0]    m_hit_level
);

    // tag = floor(address / LINE_BYTES) via exact reciprocal multiply
    localparam int FLOOR_LOG   = $clog2(LINE_BYTES + 1) - 1;
    localparam int CEIL_LOG    = $clog2(LINE_BYTES);
    localparam int RECIP_SHIFT = ADDR_WIDTH + CEIL_LOG;
    localparam int RECIP_W     = ADDR_WIDTH + 2;
    localparam int PROD_W      = 2 * ADDR_WIDTH + 2;
    localparam int TAG_W       = (ADDR_WIDTH > FLOOR_LOG) ? (ADDR_WIDTH - FLOOR_LOG) : 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(LINE_BYTES) - 1)
                 / longint'(LINE_BYTES));

    logic [PROD_W-1:0] product;
    logic [TAG_W-1:0]  tag_next;
    logic [TAG_W-1:0]  tag_reg;
    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    level_code_t       level_reg;
    level_code_t       level_next;
    logic              s_fire;
    logic              lookup_fire;
    logic              l1_hit;
    logic              l2_hit;
    logic              l3_hit;

    assign product  = PROD_W'(s_address) * PROD_W'(RECIP);
    assign tag_next = product[RECIP_SHIFT +: TAG_W];

    assign s_ready     = !busy_reg;
    assign s_fire      = s_valid && s_ready;
    assign lookup_fire = busy_reg && (!out_valid_reg || m_ready);

    tllc_level #(
        .LINES (FIRST_LINES),
        .TAG_W (TAG_W)
    ) u_l1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (lookup_fire),
        .probe_tag (tag_reg),
        .hit       (l1_hit)
    );

    tllc_level #(
        .LINES (SECOND_LINES),
        .TAG_W (TAG_W)
    ) u_l2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (lookup_fire && !l1_hit),
        .probe_tag (tag_reg),
        .hit       (l2_hit)
    );

    tllc_level #(
        .LINES (THIRD_LINES),
        .TAG_W (TAG_W)
    ) u_l3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (lookup_fire && !l1_hit && !l2_hit),
        .probe_tag (tag_reg),
        .hit       (l3_hit)
    );

    always_comb begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s_fire) begin
            busy_next = 1'b1;
        end
        if (lookup_fire) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            if (l1_hit) begin
                level_next = HIT_L1;
            end else if (l2_hit) begin
                level_next = HIT_L2;
            end else if (l3_hit) begin
                level_next = HIT_L3;
            end else begin
                level_next = MISS_ALL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg <= level_next;
        if (s_fire) begin
            tag_reg <= tag_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_hit_level = level_reg;

endmodule

// ===== rtl/tllc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllc_checker
// Port-level checks on the lookup block's request/result timing.
// ----------------------------------------------------------------------------
module tllc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_hit_level
);

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_level))
        else $error("result changed or dropped while stalled");

    // one request in the lookup stage at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while lookup pending");

    // a request taken while the output is free yields a result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (!m_valid || m_ready) |-> ##2 m_valid)
        else $error("result missing two cycles after request");

    // a new result only follows a lookup cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a pending lookup");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind three_level_lru_cache_lookup_top tllc_checker u_tllc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hit_level (m_hit_level)
);
